### rtl/cfe_pkg.sv
`default_nettype none

package cfe_pkg;

    localparam int FORCE_LIMIT     = 16383;
    localparam int TYPE_GAIN_UNITY = 1024;
    localparam int COEF_SHIFT      = 14;
    localparam int FRIC_SHIFT      = 8;
    localparam int SCALE_SHIFT     = 8;
    localparam int TYPE_GAIN_SHIFT = 10;
    localparam int FRICTION_KNEE   = 256;
    localparam int SPRING_SCALE    = 128;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [11:0] SCALE_RESET = 12'd256;

    // Configuration register indexes.
    localparam logic [1:0] CFG_DAMPER   = 2'd0;
    localparam logic [1:0] CFG_INERTIA  = 2'd1;
    localparam logic [1:0] CFG_FRICTION = 2'd2;

    typedef enum logic [1:0] {
        MODE_SPRING   = 2'd0,
        MODE_DAMPER   = 2'd1,
        MODE_INERTIA  = 2'd2,
        MODE_FRICTION = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        KIND_ZERO       = 2'd0,
        KIND_COND       = 2'd1,
        KIND_FRIC_FULL  = 2'd2,
        KIND_FRIC_SLOPE = 2'd3
    } t_kind;

    // Effect parameters carried through the front stages.
    typedef struct packed {
        logic signed [15:0] cp;
        logic [14:0]        db;
        logic signed [15:0] pc;
        logic signed [15:0] nc;
        logic [14:0]        ps;
        logic [14:0]        ns;
        logic [7:0]         eg;
        logic [14:0]        tg;
    } t_par;

    // One classified item waiting for the back end.
    typedef struct packed {
        t_kind              kind;
        logic signed [18:0] opnd;
        logic signed [16:0] coef;
        logic [14:0]        lim;
        logic               no_limit;
        logic [7:0]         eg;
        logic [14:0]        tg;
    } t_qentry;

    function automatic logic signed [15:0] sat16(input logic signed [39:0] x);
        logic signed [15:0] r;
        if (x > 40'sd32767) begin
            r = 16'sh7fff;
        end else if (x < -40'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = x[15:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/cfe_front.sv
`default_nettype none

module cfe_front #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic [1:0]                         i_mode,
    input  wire logic signed [15:0]                 i_axis_position,
    input  wire logic signed [15:0]                 i_axis_velocity,
    input  wire logic signed [15:0]                 i_axis_accel,
    input  wire cfe_pkg::t_par                      i_par,
    input  wire logic                               i_cfg_valid,
    input  wire logic [1:0]                         i_cfg_index,
    input  wire logic [11:0]                        i_cfg_data,
    input  wire logic [$clog2(QUEUE_DEPTH+1)-1:0]   i_level,
    output logic                                    o_push,
    output cfe_pkg::t_qentry                        o_entry
);
    import cfe_pkg::*;

    localparam int LEVEL_W = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W   = LEVEL_W + 2;
    localparam logic signed [15:0] KNEE = 16'(FRICTION_KNEE);

    logic [11:0] r_damper, r_inertia, r_friction;

    // Stage 1 registers.
    logic               r_v1;
    t_mode              r_mode1;
    logic               r_zero1;
    logic signed [28:0] r_prod1;
    t_par               r_par1;

    // Stage 2 registers.
    logic               r_v2;
    t_mode              r_mode2;
    logic               r_zero2;
    logic signed [15:0] r_val2;
    t_par               r_par2;

    logic               accept;
    logic [SUM_W-1:0]   occ;
    logic signed [15:0] x_sel;
    logic [11:0]        sc_sel;
    logic               zero_sel;
    logic signed [28:0] mul1;
    logic [1:0]         sgn_acc, sgn_vel;

    logic signed [17:0] v18, lo, hi, db18, neg_v;
    logic signed [18:0] d_lo, d_hi;
    logic signed [15:0] t_pos, t_neg, t_sel, neg_nc, fcoef;
    logic               below, above, vpos;
    t_qentry            n_entry;

    // Items in the queue plus items still in the front stages reserve slots.
    assign occ    = SUM_W'(i_level) + SUM_W'(r_v1) + SUM_W'(r_v2);
    assign busy   = (occ >= SUM_W'(QUEUE_DEPTH));
    assign accept = start && !busy;

    assign sgn_acc = {i_axis_accel == 16'sd0, i_axis_accel[15]};
    assign sgn_vel = {i_axis_velocity == 16'sd0, i_axis_velocity[15]};

    always_comb begin
        x_sel    = i_axis_position;
        sc_sel   = 12'(SPRING_SCALE);
        zero_sel = 1'b0;
        case (t_mode'(i_mode))
            MODE_SPRING: begin
                x_sel  = i_axis_position;
                sc_sel = 12'(SPRING_SCALE);
            end
            MODE_DAMPER: begin
                x_sel  = i_axis_velocity;
                sc_sel = r_damper;
            end
            MODE_INERTIA: begin
                x_sel    = i_axis_accel;
                sc_sel   = r_inertia;
                zero_sel = (sgn_acc == sgn_vel);
            end
            MODE_FRICTION: begin
                x_sel    = i_axis_velocity;
                sc_sel   = r_friction;
                zero_sel = (i_axis_velocity == 16'sd0);
            end
            default: begin
                x_sel  = i_axis_position;
                sc_sel = 12'(SPRING_SCALE);
            end
        endcase
    end

    // Spring is scaled by one half as a multiply by 128 followed by the shared shift.
    assign mul1 = 29'(x_sel) * 29'($signed({1'b0, sc_sel}));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_damper   <= SCALE_RESET;
            r_inertia  <= SCALE_RESET;
            r_friction <= SCALE_RESET;
            r_v1       <= 1'b0;
            r_v2       <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_DAMPER:   r_damper   <= i_cfg_data;
                    CFG_INERTIA:  r_inertia  <= i_cfg_data;
                    CFG_FRICTION: r_friction <= i_cfg_data;
                    default:      ;
                endcase
            end
            r_v1 <= accept;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode1 <= t_mode'(i_mode);
        r_zero1 <= zero_sel;
        r_prod1 <= mul1;
        r_par1  <= i_par;
        r_mode2 <= r_mode1;
        r_zero2 <= r_zero1;
        r_val2  <= sat16(40'(r_prod1 >>> SCALE_SHIFT));
        r_par2  <= r_par1;
    end

    // Classification: dead band test for the condition modes, knee test for friction.
    assign v18   = 18'(r_val2);
    assign db18  = $signed({3'b000, r_par2.db});
    assign lo    = 18'(r_par2.cp) - db18;
    assign hi    = 18'(r_par2.cp) + db18;
    assign below = (v18 < lo);
    assign above = (v18 > hi);
    assign d_lo  = 19'(v18) - 19'(lo);
    assign d_hi  = 19'(v18) - 19'(hi);

    assign vpos   = (r_val2 > 16'sd0);
    assign neg_v  = -v18;
    assign t_pos  = sat16(40'(v18 - db18));
    assign t_neg  = sat16(40'(neg_v - db18));
    assign neg_nc = sat16(40'(-18'(r_par2.nc)));
    assign t_sel  = vpos ? t_pos : t_neg;
    assign fcoef  = vpos ? r_par2.pc : neg_nc;

    always_comb begin
        n_entry          = '0;
        n_entry.kind     = KIND_ZERO;
        n_entry.eg       = r_par2.eg;
        n_entry.tg       = r_par2.tg;
        if (!r_zero2) begin
            if (r_mode2 == MODE_FRICTION) begin
                n_entry.coef = 17'(fcoef);
                n_entry.opnd = 19'(t_sel);
                if (t_sel > KNEE) begin
                    n_entry.kind = KIND_FRIC_FULL;
                end else if (t_sel > 16'sd0) begin
                    n_entry.kind = KIND_FRIC_SLOPE;
                end
            end else if (below) begin
                n_entry.kind     = KIND_COND;
                n_entry.opnd     = d_lo;
                n_entry.coef     = 17'(r_par2.nc);
                n_entry.lim      = r_par2.ns;
                n_entry.no_limit = (r_mode2 == MODE_INERTIA) && (r_par2.ns == 15'd0);
            end else if (above) begin
                n_entry.kind     = KIND_COND;
                n_entry.opnd     = d_hi;
                n_entry.coef     = 17'(r_par2.pc);
                n_entry.lim      = r_par2.ps;
                n_entry.no_limit = (r_mode2 == MODE_INERTIA) && (r_par2.ps == 15'd0);
            end
        end
    end

    assign o_push  = r_v2;
    assign o_entry = n_entry;

endmodule

`default_nettype wire

### rtl/cfe_queue.sv
`default_nettype none

module cfe_queue #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_push,
    input  wire cfe_pkg::t_qentry                   i_entry,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]        o_level,
    output logic                                    o_valid,
    output cfe_pkg::t_qentry                        o_entry
);
    import cfe_pkg::*;

    localparam int AW      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int LEVEL_W = $clog2(QUEUE_DEPTH + 1);

    t_qentry            mem [QUEUE_DEPTH];
    logic [AW-1:0]      r_wptr, r_rptr;
    logic [LEVEL_W-1:0] r_level;
    logic               r_valid;
    t_qentry            r_data;
    logic               pop;

    // The back end never stalls, so any stored entry is read out at once.
    assign pop = (r_level != '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            mem[r_wptr] <= i_entry;
        end
        if (pop) begin
            r_data <= mem[r_rptr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_level <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= pop;
            if (i_push) begin
                r_wptr <= (r_wptr == AW'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (pop) begin
                r_rptr <= (r_rptr == AW'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            case ({i_push, pop})
                2'b10:   r_level <= r_level + 1'b1;
                2'b01:   r_level <= r_level - 1'b1;
                default: r_level <= r_level;
            endcase
        end
    end

    assign o_level = r_level;
    assign o_valid = r_valid;
    assign o_entry = r_data;

`ifndef SYNTHESIS
    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_level <= LEVEL_W'(QUEUE_DEPTH))
        else $error("queue level above depth");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_level < LEVEL_W'(QUEUE_DEPTH)))
        else $error("push into a full queue");

    a_valid_follows_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_level != '0))
        else $error("queue output without a stored entry");
`endif

endmodule

`default_nettype wire

### rtl/cfe_back.sv
`default_nettype none

module cfe_back (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_take,
    input  wire cfe_pkg::t_qentry       i_entry,
    output logic                        o_valid,
    output logic signed [14:0]          o_force_res
);
    import cfe_pkg::*;

    localparam logic signed [31:0] TG_LIM = 32'(FORCE_LIMIT * TYPE_GAIN_UNITY);

    logic               r_bv1, r_bv2, r_bv3, r_bv4, r_bv5;

    // B1: coefficient product.
    t_kind              r_kind1;
    logic signed [35:0] r_p1;
    logic signed [16:0] r_coef1;
    logic [14:0]        r_lim1;
    logic               r_nolim1;
    logic [7:0]         r_eg1;
    logic [14:0]        r_tg1;
    // B2: shaped force.
    logic signed [15:0] r_f2;
    logic [7:0]         r_eg2;
    logic [14:0]        r_tg2;
    // B3: after effect gain.
    logic signed [15:0] r_g3;
    logic [14:0]        r_tg3;
    logic               r_mute3;
    // B4: type gain product.
    logic signed [31:0] r_p4;
    logic               r_mute4;
    // B5: output.
    logic signed [14:0] r_out;

    logic signed [21:0] cs;
    logic signed [21:0] lim22;
    logic signed [21:0] cl;
    logic signed [15:0] n_f;
    logic signed [25:0] pe;
    logic signed [31:0] pt;

    assign lim22 = $signed({7'd0, r_lim1});
    assign cs    = r_p1[35:14];

    always_comb begin
        cl = cs;
        if (!r_nolim1) begin
            if (cs > lim22) begin
                cl = lim22;
            end else if (cs < -lim22) begin
                cl = -lim22;
            end
        end
        case (r_kind1)
            KIND_COND:       n_f = sat16(40'(cl));
            KIND_FRIC_SLOPE: n_f = sat16(40'(r_p1) >>> FRIC_SHIFT);
            KIND_FRIC_FULL:  n_f = r_coef1[15:0];
            default:         n_f = 16'sd0;
        endcase
    end

    assign pe = 26'(r_f2) * 26'($signed({2'b00, r_eg2}) + 10'sd1);

    always_comb begin
        if (r_p4 > TG_LIM) begin
            pt = TG_LIM;
        end else if (r_p4 < -TG_LIM) begin
            pt = -TG_LIM;
        end else begin
            pt = r_p4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bv1 <= 1'b0;
            r_bv2 <= 1'b0;
            r_bv3 <= 1'b0;
            r_bv4 <= 1'b0;
            r_bv5 <= 1'b0;
        end else begin
            r_bv1 <= i_take;
            r_bv2 <= r_bv1;
            r_bv3 <= r_bv2;
            r_bv4 <= r_bv3;
            r_bv5 <= r_bv4;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind1  <= i_entry.kind;
        r_p1     <= 36'(i_entry.opnd) * 36'(i_entry.coef);
        r_coef1  <= i_entry.coef;
        r_lim1   <= i_entry.lim;
        r_nolim1 <= i_entry.no_limit;
        r_eg1    <= i_entry.eg;
        r_tg1    <= i_entry.tg;

        r_f2     <= n_f;
        r_eg2    <= r_eg1;
        r_tg2    <= r_tg1;

        r_g3     <= pe[23:8];
        r_tg3    <= r_tg2;
        r_mute3  <= (r_eg2 == 8'd0) || (r_tg2 == 15'd0);

        r_p4     <= 32'(r_g3) * 32'($signed({1'b0, r_tg3}));
        r_mute4  <= r_mute3;

        r_out    <= r_mute4 ? 15'sd0 : pt[24:10];
    end

    assign o_valid     = r_bv5;
    assign o_force_res = r_out;

`ifndef SYNTHESIS
    a_fixed_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_take |-> ##5 o_valid)
        else $error("back end result missing after five stages");

    a_force_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_force_res != 15'sh4000))
        else $error("force outside the clamp range");

    a_valid_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$isunknown(o_valid))
        else $error("result strobe unknown");
`endif

endmodule

`default_nettype wire

### rtl/condition_effect_force.sv
`default_nettype none

// Channel   | Direction | Handshake                          | Payload
// ----------+-----------+------------------------------------+-----------------------------
// command   | in        | start high while busy low          | i_mode, axis state, params
// config    | in        | i_cfg_valid and o_cfg_ready high   | i_cfg_index, i_cfg_data
// result    | out       | o_valid high for one cycle         | o_force_res
//
// The block accepts one command transaction per clock cycle while busy is
// low. The result of a transaction appears with o_valid after two front
// stages (input scaling multiply, then saturation), one queue write, one
// registered queue read and five back stages (coefficient multiply,
// clamp, effect gain multiply, type gain multiply, final clamp).
// Reset is synchronous and active low; it clears the queue, all valid bits
// and sets the three scale registers to 1.0 (256).
// The receiver cannot stall; busy only rises when the queue and the front
// stages together hold QUEUE_DEPTH transactions. The queue drains one entry
// per cycle, so at most three are held and busy never rises at depth four.
module condition_effect_force #(
    parameter int QUEUE_DEPTH = cfe_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // Command channel.
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [1:0]         i_mode,
    input  wire logic signed [15:0] i_axis_position,
    input  wire logic signed [15:0] i_axis_velocity,
    input  wire logic signed [15:0] i_axis_accel,
    input  wire logic signed [15:0] i_centre_offset,
    input  wire logic [14:0]        i_dead_band,
    input  wire logic signed [15:0] i_pos_coef,
    input  wire logic signed [15:0] i_neg_coef,
    input  wire logic [14:0]        i_pos_sat,
    input  wire logic [14:0]        i_neg_sat,
    input  wire logic [7:0]         i_effect_gain,
    input  wire logic [14:0]        i_type_gain,
    // Configuration channel.
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [11:0]        i_cfg_data,
    // Result channel.
    output logic                    o_valid,
    output logic signed [14:0]      o_force_res
);
    import cfe_pkg::*;

    localparam int LEVEL_W = $clog2(QUEUE_DEPTH + 1);

    t_par               par;
    logic               push;
    t_qentry            push_entry;
    logic [LEVEL_W-1:0] level;
    logic               q_valid;
    t_qentry            q_entry;

    // Configuration writes are taken in any cycle; the host must only write
    // while no transaction is in flight, which the block does not enforce.
    assign o_cfg_ready = 1'b1;

    assign par.cp = i_centre_offset;
    assign par.db = i_dead_band;
    assign par.pc = i_pos_coef;
    assign par.nc = i_neg_coef;
    assign par.ps = i_pos_sat;
    assign par.ns = i_neg_sat;
    assign par.eg = i_effect_gain;
    assign par.tg = i_type_gain;

    // The front end scales the selected axis value, applies the dead band
    // or the friction knee, and turns each transaction into a queue entry
    // that names which kind of force law the back end must apply.
    cfe_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_mode          (i_mode),
        .i_axis_position (i_axis_position),
        .i_axis_velocity (i_axis_velocity),
        .i_axis_accel    (i_axis_accel),
        .i_par           (par),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_level         (level),
        .o_push          (push),
        .o_entry         (push_entry)
    );

    // Short queue between the two halves.
    cfe_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .o_level (level),
        .o_valid (q_valid),
        .o_entry (q_entry)
    );

    // The back end applies the coefficient and saturation, then the effect
    // and type gains, and drives the registered result.
    cfe_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (q_valid),
        .i_entry     (q_entry),
        .o_valid     (o_valid),
        .o_force_res (o_force_res)
    );

endmodule

`default_nettype wire
